// File: hw/rtl/hbs_pkg.sv
// ----------------------------------------------------------------------------
// hbs_pkg: shared definitions for the height-map bilinear sampler
// Widths, register reset values, CSR indexes, sequencer states and the
// control word of the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
package hbs_pkg;

   // map geometry and fixed-point format
   localparam int MAP_BITS  = 10;                  // log2 of the map side
   localparam int FRAC_BITS = 8;
   localparam int COORD_W   = 20;                  // signed Q11.8
   localparam int HEIGHT_W  = 16;                  // raw stored height
   localparam int SCALE_W   = 24;                  // Q0.24 metres per unit
   localparam int ADDR_W    = 2 * MAP_BITS;        // row * side + col
   localparam int WEIGHT_W  = FRAC_BITS + 1;       // holds 1.0
   localparam int LERP_W    = HEIGHT_W + FRAC_BITS;      // one z lerp
   localparam int OPA_W     = HEIGHT_W + 2 * FRAC_BITS;  // full bilinear sum
   localparam int ACC_W     = OPA_W + SCALE_W;           // scaled product
   localparam int OUT_W     = 16;

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1 << FRAC_BITS);

   // configuration reset values
   localparam logic signed [COORD_W-1:0] CLAMP_LOW_RST  = 20'sd0;
   localparam logic signed [COORD_W-1:0] CLAMP_HIGH_RST = 20'sd261888;
   localparam logic [SCALE_W-1:0]        SCALE_RST      = 24'd51252;

   // request kinds carried in tuser
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef enum logic [1:0] {
      CSR_CLAMP_LOW   = 2'd0,
      CSR_CLAMP_HIGH  = 2'd1,
      CSR_MAP_PRESENT = 2'd2,
      CSR_SCALE       = 2'd3
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLAMP,
      ST_ADDR,
      ST_MAC,
      ST_OUT
   } state_type;

   // multiply-accumulate steps of one query
   typedef enum logic [2:0] {
      STEP_A0,      // acc  = s00 * (1-fz)
      STEP_A1,      // acc += s10 * fz          -> a
      STEP_B0,      // acc  = s01 * (1-fz), keep a
      STEP_B1,      // acc += s11 * fz          -> b
      STEP_HX1,     // acc  = b * fx
      STEP_HX0,     // acc += a * (1-fx)        -> h
      STEP_SCALE    // acc  = h * height_scale
   } mac_step_type;

   typedef enum logic [1:0] {
      OPA_RDATA,
      OPA_SAVED,
      OPA_ACC
   } opa_sel_type;

   typedef enum logic [2:0] {
      OPB_INV_FZ,
      OPB_FZ,
      OPB_FX,
      OPB_INV_FX,
      OPB_SCALE
   } opb_sel_type;

   typedef struct packed {
      logic        en;       // update accumulator
      logic        clear;    // load product instead of adding
      logic        save_a;   // copy accumulator into the saved lerp
      opa_sel_type opa_sel;
      opb_sel_type opb_sel;
   } mac_ctl_type;

endpackage

// File: hw/rtl/heightmap_bilinear_sampler.sv
// ----------------------------------------------------------------------------
// heightmap_bilinear_sampler: bilinear height lookup over a 1024x1024 map
//
// Request words arrive on req_*; tuser selects a store write (0) or a height
// query (1). A write stores entry_value at (entry_row, entry_col) in the
// accept cycle and gives no response word. A query clamps x and z to the
// CSR bounds, reads the four surrounding corners from the single-port height
// memory, interpolates in z then x and scales to metres in Q8.8; one word
// comes out on rsp_*. With map_present clear the query answers 0.
// Sequence: a query with a map loaded passes from its accept through clamp,
// one read lead-in, seven steps of the one shared multiplier and output
// load; rsp_tvalid rises and req_tready returns in the same cycle. Without
// a map a query goes from accept straight to output load. A write leaves
// the sequencer idle, so the next request can be accepted right after it.
// The block takes one request at a time. A query waits in its output-load
// step while an earlier response is still held by a stalled receiver.
// Reset restores the CSR defaults and idles the sequencer; the height store
// keeps no reset value and must be written before it is read. CSRs are
// written by the user via csr_we/csr_index/csr_wdata only while idle; unenforced.
// ----------------------------------------------------------------------------
module heightmap_bilinear_sampler (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // entry_row, entry_col, entry_value, query_x, query_z
   input  logic        req_tuser,   // req_type
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // height
   // configuration
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   localparam int MB = hbs_pkg::MAP_BITS;
   localparam int FB = hbs_pkg::FRAC_BITS;
   localparam int CW = hbs_pkg::COORD_W;

   // configuration registers
   logic signed [CW-1:0]          clamp_low_ff;
   logic signed [CW-1:0]          clamp_high_ff;
   logic                          map_present_ff;
   logic [hbs_pkg::SCALE_W-1:0]   scale_ff;

   // request fields
   logic [MB-1:0]                 entry_row;
   logic [MB-1:0]                 entry_col;
   logic [hbs_pkg::HEIGHT_W-1:0]  entry_value;
   logic signed [CW-1:0]          query_x;
   logic signed [CW-1:0]          query_z;

   // query state
   hbs_pkg::state_type            state_ff, state_in;
   hbs_pkg::mac_step_type         step_ff, step_in;
   logic signed [CW-1:0]          x_ff, z_ff;
   logic [FB-1:0]                 fx_ff, fz_ff;
   logic [MB-1:0]                 col_ff, zi_ff;
   logic                          zero_ff;
   logic                          rsp_valid_ff;
   logic [hbs_pkg::OUT_W-1:0]     rsp_data_ff;

   // sequencer outputs
   logic                          rd_en;
   logic [1:0]                    rd_idx;
   logic                          load_rsp;
   hbs_pkg::mac_ctl_type          mac_ctl;

   logic                          req_fire;
   logic                          wr_fire;
   logic signed [CW-1:0]          x_lo, x_cl, z_lo, z_cl;
   logic [MB-1:0]                 rd_row, rd_col;
   logic [hbs_pkg::ADDR_W-1:0]    mem_addr;
   logic [hbs_pkg::HEIGHT_W-1:0]  mem_rdata;
   logic [hbs_pkg::ACC_W-1:0]     acc;
   logic [hbs_pkg::OUT_W-1:0]     height;

   assign entry_row   = req_tdata[9:0];
   assign entry_col   = req_tdata[19:10];
   assign entry_value = req_tdata[35:20];
   assign query_x     = req_tdata[55:36];
   assign query_z     = req_tdata[75:56];

   assign req_tready = (state_ff == hbs_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign wr_fire    = req_fire && (req_tuser == hbs_pkg::REQ_WRITE);

   // CSR writes
   always_ff @(posedge clock) begin
      if (reset) begin
         clamp_low_ff   <= hbs_pkg::CLAMP_LOW_RST;
         clamp_high_ff  <= hbs_pkg::CLAMP_HIGH_RST;
         map_present_ff <= 1'b0;
         scale_ff       <= hbs_pkg::SCALE_RST;
      end else if (csr_we) begin
         unique case (hbs_pkg::csr_idx_type'(csr_index))
            hbs_pkg::CSR_CLAMP_LOW:   clamp_low_ff   <= csr_wdata[CW-1:0];
            hbs_pkg::CSR_CLAMP_HIGH:  clamp_high_ff  <= csr_wdata[CW-1:0];
            hbs_pkg::CSR_MAP_PRESENT: map_present_ff <= csr_wdata[0];
            hbs_pkg::CSR_SCALE:       scale_ff       <= csr_wdata;
            default:                  map_present_ff <= map_present_ff;
         endcase
      end
   end

   // clamp: raise to low bound, then lower to high bound
   always_comb begin
      x_lo = (x_ff < clamp_low_ff) ? clamp_low_ff : x_ff;
      x_cl = (x_lo > clamp_high_ff) ? clamp_high_ff : x_lo;
      z_lo = (z_ff < clamp_low_ff) ? clamp_low_ff : z_ff;
      z_cl = (z_lo > clamp_high_ff) ? clamp_high_ff : z_lo;
   end

   // capture query and split coordinates
   always_ff @(posedge clock) begin
      if (req_fire) begin
         x_ff    <= query_x;
         z_ff    <= query_z;
         zero_ff <= !map_present_ff;
      end
      if (state_ff == hbs_pkg::ST_CLAMP) begin
         fx_ff  <= x_cl[FB-1:0];
         fz_ff  <= z_cl[FB-1:0];
         col_ff <= x_cl[FB+MB-1:FB];
         zi_ff  <= z_cl[FB+MB-1:FB];
      end
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hbs_pkg::ST_IDLE;
         step_ff  <= hbs_pkg::STEP_A0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         hbs_pkg::ST_IDLE: begin
            if (req_fire && req_tuser == hbs_pkg::REQ_QUERY) begin
               state_in = map_present_ff ? hbs_pkg::ST_CLAMP : hbs_pkg::ST_OUT;
            end
         end
         hbs_pkg::ST_CLAMP: state_in = hbs_pkg::ST_ADDR;
         hbs_pkg::ST_ADDR: begin
            state_in = hbs_pkg::ST_MAC;
            step_in  = hbs_pkg::STEP_A0;
         end
         hbs_pkg::ST_MAC: begin
            if (step_ff == hbs_pkg::STEP_SCALE) begin
               state_in = hbs_pkg::ST_OUT;
            end else begin
               step_in = hbs_pkg::mac_step_type'(step_ff + 3'd1);
            end
         end
         hbs_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = hbs_pkg::ST_IDLE;
            end
         end
         default: state_in = hbs_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs: corner reads one step ahead of the multiplier
   always_comb begin
      rd_en    = 1'b0;
      rd_idx   = 2'd0;
      load_rsp = 1'b0;
      mac_ctl  = '{en: 1'b0, clear: 1'b0, save_a: 1'b0,
                   opa_sel: hbs_pkg::OPA_RDATA, opb_sel: hbs_pkg::OPB_INV_FZ};
      unique case (state_ff)
         hbs_pkg::ST_ADDR: rd_en = 1'b1;
         hbs_pkg::ST_MAC: begin
            mac_ctl.en = 1'b1;
            unique case (step_ff)
               hbs_pkg::STEP_A0: begin
                  rd_en = 1'b1;
                  rd_idx = 2'd1;
                  mac_ctl.clear = 1'b1;
               end
               hbs_pkg::STEP_A1: begin
                  rd_en = 1'b1;
                  rd_idx = 2'd2;
                  mac_ctl.opb_sel = hbs_pkg::OPB_FZ;
               end
               hbs_pkg::STEP_B0: begin
                  rd_en = 1'b1;
                  rd_idx = 2'd3;
                  mac_ctl.clear = 1'b1;
                  mac_ctl.save_a = 1'b1;
               end
               hbs_pkg::STEP_B1: mac_ctl.opb_sel = hbs_pkg::OPB_FZ;
               hbs_pkg::STEP_HX1: begin
                  mac_ctl.clear = 1'b1;
                  mac_ctl.opa_sel = hbs_pkg::OPA_ACC;
                  mac_ctl.opb_sel = hbs_pkg::OPB_FX;
               end
               hbs_pkg::STEP_HX0: begin
                  mac_ctl.opa_sel = hbs_pkg::OPA_SAVED;
                  mac_ctl.opb_sel = hbs_pkg::OPB_INV_FX;
               end
               hbs_pkg::STEP_SCALE: begin
                  mac_ctl.clear = 1'b1;
                  mac_ctl.opa_sel = hbs_pkg::OPA_ACC;
                  mac_ctl.opb_sel = hbs_pkg::OPB_SCALE;
               end
               default: mac_ctl.en = 1'b0;
            endcase
         end
         hbs_pkg::ST_OUT: load_rsp = !rsp_valid_ff || rsp_tready;
         default: rd_en = 1'b0;
      endcase
   end

   // corner address: bit 0 picks the next row, bit 1 the next column;
   // rows are mirrored, neighbors wrap around the map edge
   always_comb begin
      rd_row = rd_idx[0] ? ~(zi_ff + MB'(1)) : ~zi_ff;
      rd_col = rd_idx[1] ? (col_ff + MB'(1)) : col_ff;
   end

   assign mem_addr = wr_fire ? {entry_row, entry_col} : {rd_row, rd_col};

   hbs_height_mem u_mem (
      .clock (clock),
      .en    (wr_fire || rd_en),
      .we    (wr_fire),
      .addr  (mem_addr),
      .wdata (entry_value),
      .rdata (mem_rdata)
   );

   hbs_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .rdata (mem_rdata),
      .fx    (fx_ff),
      .fz    (fz_ff),
      .scale (scale_ff),
      .acc   (acc)
   );

   // product >> 32, saturated to 16 bits
   assign height = (|acc[hbs_pkg::ACC_W-1:48]) ? '1 : acc[47:32];

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff <= zero_ff ? '0 : height;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // the store is only written while the sequencer is idle
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != hbs_pkg::ST_IDLE) |-> !wr_fire)
      else $error("height store written during a query");

   // a query with a map loaded always goes through the clamp step
   a_query_start: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser == hbs_pkg::REQ_QUERY && map_present_ff)
      |=> (state_ff == hbs_pkg::ST_CLAMP))
      else $error("query did not start its sequence");

   // a held response is never overwritten
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hbs_pkg::ST_OUT && rsp_valid_ff && !rsp_tready)
      |=> (state_ff == hbs_pkg::ST_OUT) && $stable(rsp_data_ff))
      else $error("response lost while receiver stalled");

   // reads and writes never collide on the single port
   a_port_excl: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> !req_tready)
      else $error("read issued while accepting requests");

endmodule

// File: hw/rtl/hbs_height_mem.sv
// ----------------------------------------------------------------------------
// hbs_height_mem: single-port height store
// One access per cycle, write or read; read data is registered.
// Contents are undefined until written.
// ----------------------------------------------------------------------------
module hbs_height_mem (
   input  logic                             clock,
   input  logic                             en,
   input  logic                             we,
   input  logic [hbs_pkg::ADDR_W-1:0]       addr,
   input  logic [hbs_pkg::HEIGHT_W-1:0]     wdata,
   output logic [hbs_pkg::HEIGHT_W-1:0]     rdata
);

   logic [hbs_pkg::HEIGHT_W-1:0] mem [0:(1 << hbs_pkg::ADDR_W)-1];
   logic [hbs_pkg::HEIGHT_W-1:0] rdata_ff;

   // one port: write or registered read
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/hbs_mac.sv
// ----------------------------------------------------------------------------
// hbs_mac: shared multiply-accumulate unit
// One multiplier with operand selection; the accumulator either loads the
// product or adds it. Holds the first z lerp for the final x lerp.
// ----------------------------------------------------------------------------
module hbs_mac (
   input  logic                             clock,
   input  hbs_pkg::mac_ctl_type             ctl,
   input  logic [hbs_pkg::HEIGHT_W-1:0]     rdata,
   input  logic [hbs_pkg::FRAC_BITS-1:0]    fx,
   input  logic [hbs_pkg::FRAC_BITS-1:0]    fz,
   input  logic [hbs_pkg::SCALE_W-1:0]      scale,
   output logic [hbs_pkg::ACC_W-1:0]        acc
);

   logic [hbs_pkg::ACC_W-1:0]    acc_ff;
   logic [hbs_pkg::ACC_W-1:0]    acc_in;
   logic [hbs_pkg::LERP_W-1:0]   saved_ff;
   logic [hbs_pkg::OPA_W-1:0]    opa;
   logic [hbs_pkg::SCALE_W-1:0]  opb;
   logic [hbs_pkg::ACC_W-1:0]    prod;
   logic [hbs_pkg::WEIGHT_W-1:0] inv_fx;
   logic [hbs_pkg::WEIGHT_W-1:0] inv_fz;

   // complementary weights, 1.0 - fraction
   assign inv_fx = hbs_pkg::WEIGHT_ONE - {1'b0, fx};
   assign inv_fz = hbs_pkg::WEIGHT_ONE - {1'b0, fz};

   // operand A select
   always_comb begin
      case (ctl.opa_sel)
         hbs_pkg::OPA_RDATA: opa = hbs_pkg::OPA_W'(rdata);
         hbs_pkg::OPA_SAVED: opa = hbs_pkg::OPA_W'(saved_ff);
         hbs_pkg::OPA_ACC:   opa = acc_ff[hbs_pkg::OPA_W-1:0];
         default:            opa = '0;
      endcase
   end

   // operand B select
   always_comb begin
      case (ctl.opb_sel)
         hbs_pkg::OPB_INV_FZ: opb = hbs_pkg::SCALE_W'(inv_fz);
         hbs_pkg::OPB_FZ:     opb = hbs_pkg::SCALE_W'(fz);
         hbs_pkg::OPB_FX:     opb = hbs_pkg::SCALE_W'(fx);
         hbs_pkg::OPB_INV_FX: opb = hbs_pkg::SCALE_W'(inv_fx);
         hbs_pkg::OPB_SCALE:  opb = scale;
         default:             opb = '0;
      endcase
   end

   // multiply, then load or accumulate
   assign prod   = hbs_pkg::ACC_W'(opa) * hbs_pkg::ACC_W'(opb);
   assign acc_in = ctl.clear ? prod : acc_ff + prod;

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         acc_ff <= acc_in;
      end
      if (ctl.save_a) begin
         saved_ff <= acc_ff[hbs_pkg::LERP_W-1:0];
      end
   end

   assign acc = acc_ff;

endmodule

// File: test/heightmap_bilinear_sampler_tb.sv
// ----------------------------------------------------------------------------
// heightmap_bilinear_sampler_tb: self-checking bench for the height sampler
// Streams store writes and height queries into the block, keeps a shadow
// copy of the height store and CSRs, and predicts every response word from
// the clamped coordinates, the four corner heights and the height scale.
// Corners a query touches are written first, so no unwritten entry is read.
// ----------------------------------------------------------------------------
module heightmap_bilinear_sampler_tb;

   localparam int STALL_LIMIT = 2000;   // cycles with no traffic at all

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata  = '0;
   logic        req_tuser  = hbs_pkg::REQ_WRITE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_index  = hbs_pkg::CSR_CLAMP_LOW;
   logic [23:0] csr_wdata  = '0;

   // shadow state
   logic [15:0]                        height_mem [logic [19:0]];
   logic [19:0]                        written_addrs [$];
   logic [15:0]                        pending_heights [$];
   logic signed [hbs_pkg::COORD_W-1:0] cfg_clamp_low   = hbs_pkg::CLAMP_LOW_RST;
   logic signed [hbs_pkg::COORD_W-1:0] cfg_clamp_high  = hbs_pkg::CLAMP_HIGH_RST;
   logic                               cfg_map_present = 1'b0;
   logic [hbs_pkg::SCALE_W-1:0]        cfg_scale       = hbs_pkg::SCALE_RST;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int errors        = 0;
   int n_writes      = 0;
   int n_queries     = 0;
   int n_checked     = 0;
   int n_csr         = 0;
   int stall_cycles  = 0;
   logic [15:0] due_height;

   heightmap_bilinear_sampler dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // receiver backpressure
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_heights.size() == 0) begin
            $display("%0t: response word %h with no query pending", $time, rsp_tdata);
            errors++;
         end else begin
            due_height = pending_heights.pop_front();
            n_checked++;
            if (rsp_tdata !== due_height) begin
               $display("%0t: height mismatch, expected %h, got %h",
                        $time, due_height, rsp_tdata);
               errors++;
            end
         end
      end
   end

   // watchdog: no word moved for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no traffic for %0d cycles", $time, STALL_LIMIT);
         $display("[heightmap_bilinear_sampler] ERROR");
         $finish;
      end
   end

   // clamp, split into integer and fraction, find the four corners
   // corner order: (row0,col0) (row1,col0) (row0,col1) (row1,col1)
   function automatic void locate_corners(input logic [19:0] qx, qz,
                                          output logic [3:0][19:0] corner,
                                          output logic [7:0] fx, fz);
      logic signed [19:0] cx, cz;
      logic [9:0] col0, col1, row0, row1, iz_next;
      cx = qx;
      cz = qz;
      if (cx < cfg_clamp_low)  cx = cfg_clamp_low;
      if (cx > cfg_clamp_high) cx = cfg_clamp_high;
      if (cz < cfg_clamp_low)  cz = cfg_clamp_low;
      if (cz > cfg_clamp_high) cz = cfg_clamp_high;
      fx = cx[7:0];
      fz = cz[7:0];
      // floor mod 1024 is just bits 17:8; row mirror is 1023 - v = ~v
      col0 = cx[17:8];
      col1 = col0 + 10'd1;
      row0 = ~cz[17:8];
      iz_next = cz[17:8] + 10'd1;
      row1 = ~iz_next;
      corner[0] = {row0, col0};
      corner[1] = {row1, col0};
      corner[2] = {row0, col1};
      corner[3] = {row1, col1};
   endfunction

   function automatic logic [15:0] predict_height(input logic [19:0] qx, qz);
      logic [3:0][19:0] corner;
      logic [7:0] fx, fz;
      logic [63:0] lerp_a, lerp_b, mix, scaled;
      if (!cfg_map_present) return 16'd0;
      locate_corners(qx, qz, corner, fx, fz);
      lerp_a = 64'(height_mem[corner[0]]) * (64'd256 - fz) + 64'(height_mem[corner[1]]) * fz;
      lerp_b = 64'(height_mem[corner[2]]) * (64'd256 - fz) + 64'(height_mem[corner[3]]) * fz;
      mix    = lerp_a * (64'd256 - fx) + lerp_b * fx;
      scaled = (mix * cfg_scale) >> 32;
      return (scaled > 64'hFFFF) ? 16'hFFFF : scaled[15:0];
   endfunction

   function automatic logic [19:0] random_coord();
      case ($urandom_range(3))
         0: return 20'($urandom);
         1: return {2'($urandom), ($urandom_range(1) ? 10'd1023 : 10'd0), 8'($urandom)};
         2: return 20'($urandom_range(262143));
         default: return 20'(-$urandom_range(4096, 1));
      endcase
   endfunction

   // present one request word, update the shadow model on accept
   // entered and left at a falling edge; tvalid stays high for back-to-back words
   task automatic send_word(input logic kind, input logic [79:0] word);
      logic [19:0] key;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (kind == hbs_pkg::REQ_WRITE) begin
         key = {word[9:0], word[19:10]};
         if (!height_mem.exists(key)) written_addrs.push_back(key);
         height_mem[key] = word[35:20];
         n_writes++;
      end else begin
         pending_heights.push_back(predict_height(word[55:36], word[75:56]));
         n_queries++;
      end
      @(negedge clock);
   endtask

   // unused x/z fields carry junk, the block must ignore them
   task automatic send_write(input logic [9:0] row, col, input logic [15:0] value);
      send_word(hbs_pkg::REQ_WRITE, {4'd0, 20'($urandom), 20'($urandom), value, col, row});
   endtask

   // fill any unwritten corner first so the query reads defined data
   task automatic send_query(input logic [19:0] qx, qz);
      logic [3:0][19:0] corner;
      logic [7:0] fx, fz;
      if (cfg_map_present) begin
         locate_corners(qx, qz, corner, fx, fz);
         for (int i = 0; i < 4; i++)
            if (!height_mem.exists(corner[i]))
               send_write(corner[i][19:10], corner[i][9:0], 16'($urandom));
      end
      send_word(hbs_pkg::REQ_QUERY,
                {4'd0, qz, qx, 16'($urandom), 10'($urandom), 10'($urandom)});
   endtask

   // drop valid, wait out every response, then let the block settle
   task automatic wait_idle(input int settle);
      req_tvalid <= 1'b0;
      while (pending_heights.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic write_csr(input hbs_pkg::csr_idx_type idx, input logic [23:0] value);
      wait_idle(16);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (idx)
         hbs_pkg::CSR_CLAMP_LOW:   cfg_clamp_low   = value[19:0];
         hbs_pkg::CSR_CLAMP_HIGH:  cfg_clamp_high  = value[19:0];
         hbs_pkg::CSR_MAP_PRESENT: cfg_map_present = value[0];
         hbs_pkg::CSR_SCALE:       cfg_scale       = value;
         default: ;
      endcase
      n_csr++;
   endtask

   task automatic configure(input logic [19:0] lo, hi, input logic map,
                            input logic [23:0] scale);
      write_csr(hbs_pkg::CSR_CLAMP_LOW,   {4'd0, lo});
      write_csr(hbs_pkg::CSR_CLAMP_HIGH,  {4'd0, hi});
      write_csr(hbs_pkg::CSR_MAP_PRESENT, {23'd0, map});
      write_csr(hbs_pkg::CSR_SCALE,       scale);
   endtask

   // count covers corner fills too, so the word total stays near the target
   task automatic random_items(input int count);
      logic [19:0] key;
      int goal;
      goal = n_writes + n_queries + count;
      while (n_writes + n_queries < goal) begin
         if ($urandom_range(99) < 30) begin
            // rewrite a known entry half the time, else anywhere in the map
            if (written_addrs.size() != 0 && $urandom_range(1))
               key = written_addrs[$urandom_range(written_addrs.size() - 1)];
            else
               key = 20'($urandom);
            case ($urandom_range(3))
               0:       send_write(key[19:10], key[9:0], 16'd0);
               1:       send_write(key[19:10], key[9:0], 16'hFFFF);
               default: send_write(key[19:10], key[9:0], 16'($urandom));
            endcase
         end else begin
            send_query(random_coord(), random_coord());
         end
      end
   endtask

   // queries with the reset CSRs: no map, every answer is zero
   task automatic test_no_map();
      send_query(20'h80000, 20'h7FFFF);
      send_write(10'd1023, 10'd1023, 16'hFFFF);
      send_write(10'd0, 10'd1023, 16'd0);
      send_query(20'd0, 20'd0);
   endtask

   // hand-picked corners, wraps, negative coordinates and CSR extremes
   task automatic test_directed_queries();
      configure(20'h80000, 20'h7FFFF, 1'b1, hbs_pkg::SCALE_RST);
      // full-scale corners around the origin (rows 1023/1022, cols 0/1)
      send_write(10'd1023, 10'd0, 16'hFFFF);
      send_write(10'd1022, 10'd0, 16'hFFFF);
      send_write(10'd1023, 10'd1, 16'hFFFF);
      send_write(10'd1022, 10'd1, 16'hFFFF);
      send_write(10'd0, 10'd0, 16'd0);
      send_query(20'd0, 20'd0);                   // exact corner
      send_query(20'h00080, 20'h00080);           // cell center
      send_query(20'h00080, 20'h3FF80);           // row index wraps
      send_query(20'h3FF40, 20'h00040);           // column index wraps
      send_query(20'hFFE80, 20'hFFFFF);           // negative, floor below zero
      send_query(20'h80000, 20'h7FFFF);           // field extremes
      // crossed bounds: the upper bound wins
      write_csr(hbs_pkg::CSR_CLAMP_LOW,  {4'd0, 20'h01000});
      write_csr(hbs_pkg::CSR_CLAMP_HIGH, {4'd0, 20'h00180});
      send_query(20'h7FFFF, 20'h80000);
      send_query(20'h00000, 20'h00000);
      // scale extremes: saturation, then a zero result
      configure(20'h80000, 20'h7FFFF, 1'b1, 24'hFFFFFF);
      send_query(20'd0, 20'd0);
      send_query(20'h00080, 20'h00080);
      write_csr(hbs_pkg::CSR_SCALE, 24'd0);
      send_query(20'h00080, 20'h00080);
   endtask

   // random traffic under three backpressure profiles and several CSR sets
   task automatic test_random_traffic();
      send_idle_pct = 35;
      recv_idle_pct = 80;
      configure(20'h80000, 20'h7FFFF, 1'b1, hbs_pkg::SCALE_RST);
      random_items(70);
      configure(20'(-$urandom_range(524288)), 20'($urandom_range(524287)), 1'b1,
                24'($urandom));
      random_items(65);

      send_idle_pct = 80;
      recv_idle_pct = 35;
      configure(20'h80000, 20'($urandom_range(524287, 1024)), 1'b1, 24'($urandom));
      random_items(70);
      wait_idle(1);                               // sender holds off until drained
      random_items(65);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(hbs_pkg::CSR_MAP_PRESENT, 24'd0);
      random_items(20);
      configure(20'h80000, 20'h7FFFF, 1'b1, 24'hFFFFFF);
      random_items(115);
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 35;
      recv_idle_pct = 80;
      test_no_map();
      test_directed_queries();
      test_random_traffic();
      wait_idle(24);
      $display("run covered %0d store writes and %0d queries, %0d responses checked,",
               n_writes, n_queries, n_checked);
      $display("%0d CSR writes across clamp, map and scale settings", n_csr);
      if (errors == 0)
         $display("[heightmap_bilinear_sampler] OK");
      else
         $display("[heightmap_bilinear_sampler] ERROR");
      $finish;
   end

endmodule
